// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file rsp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsp assertion failed");

`endif

// ===== rtl/core/rsp_pkg.sv =====
`default_nettype none

package rsp_pkg;

	localparam int MSG_LEN     = 15;
	localparam int IDX_W       = $clog2(MSG_LEN);
	localparam int POS_W       = IDX_W + 1;
	localparam int MAG_W       = 14;
	localparam int VAL_W       = 15;
	localparam int ST_W        = 3;
	localparam int HDR_LEN     = 5;
	localparam int HDR_IDX_W   = $clog2(HDR_LEN);
	localparam int FIELD_CHARS = 4;
	localparam int CNT_W       = $clog2(FIELD_CHARS);
	localparam int WEIGHT_W    = 10;

	typedef logic [7:0]      char_t;
	typedef logic [ST_W-1:0] status_t;

	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_COMMA = 8'h2C;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_OVERFLOW  = 3'd1;
	localparam status_t ST_HEADER    = 3'd2;
	localparam status_t ST_BAD_YAW   = 3'd3;
	localparam status_t ST_BAD_SPEED = 3'd4;

	localparam logic [MAG_W-1:0] MAG_RESET = 14'd100;

	localparam char_t HDR_TEXT [HDR_LEN] = '{8'h24, 8'h52, 8'h45, 8'h46, 8'h2C};

	localparam logic [WEIGHT_W-1:0] DIGIT_WEIGHT [FIELD_CHARS] =
		'{10'd1, 10'd10, 10'd100, 10'd1000};

endpackage

`default_nettype wire

// ===== rtl/core/ref_sentence_parser.sv =====
// Throughput: one byte per cycle between terminators while idle. A byte that
// ends no message gives no word, unless it fills the buffer: an overflow word.
// A '*' runs the header check and the backward field scan through one memory
// read port and one multiply-add unit, reading then evaluating bytes in turn,
// then waits for the output register to be free. Reset is asynchronous, active
// low: write position and held values clear to zero, the limit to 100.
`default_nettype none

module ref_sentence_parser import rsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte [7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // yaw_value [14:0], speed_value [29:15], zero [31:30]
	output logic [3:0]  m_axis_tuser,  // status [2:0], yaw_updated [3]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data       // max_magnitude [13:0]
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HRD  = 3'd1;
	localparam logic [2:0] S_HEV  = 3'd2;
	localparam logic [2:0] S_FRD  = 3'd3;
	localparam logic [2:0] S_FEV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] wr_pos_q;
	logic [IDX_W-1:0] star_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             check_q;
	logic             digits_q;
	logic             neg_q;
	logic             fld_q;
	logic [MAG_W-1:0] acc_q;
	logic [MAG_W-1:0] max_q;
	logic [VAL_W-1:0] held_yaw_q;
	logic [VAL_W-1:0] held_speed_q;
	status_t          res_status_q;
	logic             res_upd_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [VAL_W-1:0] out_yaw_q;
	logic [VAL_W-1:0] out_speed_q;
	logic             out_upd_q;

	char_t            mem [MSG_LEN];
	char_t            rdata_q;

	logic             in_acc;
	logic             out_free;
	logic             is_digit;
	logic [3:0]       digit;
	logic [MAG_W-1:0] prod;
	logic [MAG_W-1:0] acc_sum;
	logic             mag_ok;
	logic [VAL_W-1:0] fld_mag;
	logic [VAL_W-1:0] fld_val;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign is_digit = (rdata_q >= CH_ZERO) && (rdata_q <= CH_NINE);
	assign digit    = 4'(rdata_q - CH_ZERO);
	assign prod     = MAG_W'(digit) * MAG_W'(DIGIT_WEIGHT[cnt_q]);
	assign acc_sum  = acc_q + prod;
	assign mag_ok   = acc_q <= max_q;
	assign fld_mag  = {1'b0, acc_q};
	assign fld_val  = neg_q ? -fld_mag : fld_mag;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_speed_q, out_yaw_q};
	assign m_axis_tuser  = {out_upd_q, out_status_q};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[wr_pos_q] <= s_axis_tdata;
		end
		rdata_q <= mem[pos_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wr_pos_q     <= '0;
			star_q       <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			check_q      <= 1'b0;
			digits_q     <= 1'b0;
			neg_q        <= 1'b0;
			fld_q        <= 1'b0;
			acc_q        <= '0;
			max_q        <= MAG_RESET;
			held_yaw_q   <= '0;
			held_speed_q <= '0;
			res_status_q <= ST_OK;
			res_upd_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_yaw_q    <= '0;
			out_speed_q  <= '0;
			out_upd_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tdata == CH_STAR) begin
							star_q    <= wr_pos_q;
							wr_pos_q  <= '0;
							pos_q     <= '0;
							res_upd_q <= 1'b0;
							state_q   <= S_HRD;
						end else if (wr_pos_q == IDX_W'(MSG_LEN - 1)) begin
							wr_pos_q     <= '0;
							res_status_q <= ST_OVERFLOW;
							res_upd_q    <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							wr_pos_q <= wr_pos_q + 1'b1;
						end
					end
				end
				S_HRD: begin
					state_q <= S_HEV;
				end
				S_HEV: begin
					if (rdata_q != HDR_TEXT[pos_q[HDR_IDX_W-1:0]]) begin
						res_status_q <= ST_HEADER;
						state_q      <= S_DONE;
					end else if (pos_q == POS_W'(HDR_LEN - 1)) begin
						pos_q    <= {1'b0, star_q} - 1'b1;
						fld_q    <= 1'b0;
						cnt_q    <= '0;
						check_q  <= 1'b0;
						digits_q <= 1'b0;
						neg_q    <= 1'b0;
						acc_q    <= '0;
						state_q  <= S_FRD;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_HRD;
					end
				end
				S_FRD: begin
					if (pos_q[POS_W-1]) begin
						res_status_q <= fld_q ? ST_BAD_SPEED : ST_BAD_YAW;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FEV;
					end
				end
				S_FEV: begin
					if (rdata_q == CH_COMMA) begin
						if (digits_q && mag_ok) begin
							if (!fld_q) begin
								held_yaw_q <= fld_val;
								res_upd_q  <= 1'b1;
								fld_q      <= 1'b1;
								pos_q      <= pos_q - 1'b1;
								cnt_q      <= '0;
								check_q    <= 1'b0;
								digits_q   <= 1'b0;
								neg_q      <= 1'b0;
								acc_q      <= '0;
								state_q    <= S_FRD;
							end else begin
								held_speed_q <= fld_val;
								res_status_q <= ST_OK;
								state_q      <= S_DONE;
							end
						end else begin
							res_status_q <= fld_q ? ST_BAD_SPEED : ST_BAD_YAW;
							state_q      <= S_DONE;
						end
					end else if (!check_q && rdata_q == CH_MINUS) begin
						neg_q   <= 1'b1;
						check_q <= 1'b1;
						pos_q   <= pos_q - 1'b1;
						state_q <= S_FRD;
					end else if (!check_q && is_digit) begin
						acc_q    <= acc_sum;
						digits_q <= 1'b1;
						pos_q    <= pos_q - 1'b1;
						cnt_q    <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(FIELD_CHARS - 1)) begin
							check_q <= 1'b1;
						end
						state_q <= S_FRD;
					end else begin
						res_status_q <= fld_q ? ST_BAD_SPEED : ST_BAD_YAW;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_yaw_q    <= held_yaw_q;
						out_speed_q  <= held_speed_q;
						out_upd_q    <= res_upd_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rsp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module rsp_checker import rsp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);

	logic        out_stall;
	logic [35:0] out_word;
	status_t     out_status;
	logic        out_upd;
	logic        yaw_kept;
	logic        star_acc;

	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign out_word   = {m_axis_tuser, m_axis_tdata};
	assign out_status = m_axis_tuser[2:0];
	assign out_upd    = m_axis_tuser[3];
	assign yaw_kept   = (out_status == ST_OK) || (out_status == ST_BAD_SPEED);
	assign star_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_STAR);

	// A stalled word keeps its contents.
	`RSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))

	`RSP_ASSERT_IMPL(a_status_code, clk, arst_n, m_axis_tvalid, out_status <= ST_BAD_SPEED)

	// A new yaw is only reported when the yaw field itself was accepted.
	`RSP_ASSERT_IMPL(a_yaw_flag, clk, arst_n, m_axis_tvalid && out_upd, yaw_kept)

	// A terminator always starts the parse, so the input side closes at once.
	`RSP_ASSERT_NEXT(a_star_busy, clk, arst_n, star_acc, !s_axis_tready)

endmodule

bind ref_sentence_parser rsp_checker u_rsp_checker (.*);

`default_nettype wire
